// File: sv/gflt_pkg.sv
package gflt_pkg;

    // Field geometry
    localparam int ELEM_W     = 7;
    localparam int FIELD_SIZE = 1 << ELEM_W;
    localparam logic [ELEM_W-1:0] ELEM_MAX  = ELEM_W'(FIELD_SIZE - 1);
    localparam logic [ELEM_W-1:0] ELEM_ZERO = ELEM_W'(0);
    localparam logic [ELEM_W-1:0] ELEM_ONE  = ELEM_W'(1);
    localparam logic [7:0]        POLY_RESET = 8'h89;

    // Command queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Operation codes on the input channel
    typedef enum logic [1:0] {
        OP_MUL   = 2'd0,
        OP_INV   = 2'd1,
        OP_CHECK = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Classified command kinds handed from front to back
    typedef enum logic [2:0] {
        CMD_MUL,
        CMD_INV,
        CMD_CHECK,
        CMD_ONE,
        CMD_ZERO,
        CMD_ERR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
    } cmd_t;

    // Command queue status
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Table build sequencer
    typedef enum logic [1:0] {
        BLD_ANTI,
        BLD_INV,
        BLD_DRAIN,
        BLD_IDLE
    } bld_state_t;

endpackage

// File: sv/gflt_front.sv
module gflt_front (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [16:0]          s_fields,   // op[1:0], operand_a[9:2], operand_b[16:10]
    input  logic                 bld_busy,
    input  gflt_pkg::q_status_t  q_stat,
    output logic                 push,
    output gflt_pkg::cmd_t       cmd
);

    gflt_pkg::op_t op;
    logic [7:0]    a_raw;

    // Unpack the transaction fields
    assign op    = gflt_pkg::op_t'(s_fields[1:0]);
    assign a_raw = s_fields[9:2];

    // Classify the operation, settle fixed results up front
    always_comb begin
        cmd.a = a_raw[gflt_pkg::ELEM_W-1:0];
        cmd.b = s_fields[16:10];
        case (op)
            gflt_pkg::OP_MUL: begin
                cmd.kind = a_raw[7] ? gflt_pkg::CMD_ERR : gflt_pkg::CMD_MUL;
            end
            gflt_pkg::OP_INV: begin
                cmd.kind = a_raw[7] ? gflt_pkg::CMD_ERR : gflt_pkg::CMD_INV;
            end
            gflt_pkg::OP_CHECK: begin
                if (a_raw[7] || (a_raw == 8'd0)) begin
                    cmd.kind = gflt_pkg::CMD_ONE;
                end else begin
                    cmd.kind = gflt_pkg::CMD_CHECK;
                end
            end
            default: begin
                cmd.kind = gflt_pkg::CMD_ZERO;
            end
        endcase
    end

    // Accept once the tables are built and the queue has room
    assign s_tready = !bld_busy && !q_stat.full;
    assign push     = s_tvalid && s_tready;

endmodule

// File: sv/gflt_fifo.sv
module gflt_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  gflt_pkg::cmd_t       push_cmd,
    input  logic                 pop,
    output gflt_pkg::cmd_t       head_cmd,
    output gflt_pkg::q_status_t  q_stat
);

    gflt_pkg::cmd_t                   mem_reg [gflt_pkg::FIFO_DEPTH];
    logic [gflt_pkg::FIFO_AW-1:0]     wr_ptr_reg;
    logic [gflt_pkg::FIFO_AW-1:0]     rd_ptr_reg;
    logic [gflt_pkg::FIFO_AW:0]       cnt_reg;
    logic [gflt_pkg::FIFO_AW:0]       cnt_next;

    localparam logic [gflt_pkg::FIFO_AW:0] CNT_FULL =
        (gflt_pkg::FIFO_AW + 1)'(gflt_pkg::FIFO_DEPTH);

    // Track the fill level
    always_comb begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    // Advance the pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Store the command
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd     = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == CNT_FULL);
    assign q_stat.empty = (cnt_reg == '0);

endmodule

// File: sv/gflt_back.sv
module gflt_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata,
    input  gflt_pkg::cmd_t       head_cmd,
    input  gflt_pkg::q_status_t  q_stat,
    output logic                 pop,
    output logic                 bld_busy,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata     // result[6:0], range_error[7]
);

    localparam int W = gflt_pkg::ELEM_W;
    localparam int N = gflt_pkg::FIELD_SIZE;

    // Polynomial and build sequencer
    logic [7:0]             poly_reg;
    gflt_pkg::bld_state_t   state_reg, state_next;
    logic [W-1:0]           cnt_reg, cnt_next;
    logic [W-1:0]           val_reg, val_next;
    logic                   bv1_reg, bv2_reg;
    logic [W-1:0]           e1_reg, e2_reg;
    logic                   anti_we;
    logic                   issue;
    logic [7:0]             dbl;
    logic [7:0]             dbl_red;

    // Tables
    logic [W-1:0]           antilog_mem [N];
    logic [W-1:0]           log_mem [N];
    logic [W-1:0]           inv_mem [N];
    logic [N-1:0]           log_vld_reg;
    logic [N-1:0]           inv_vld_reg;

    // Lookup pipeline
    logic                   adv;
    logic                   rd_en;
    logic                   p1_v_reg, p2_v_reg, p3_v_reg, out_v_reg;
    gflt_pkg::cmd_kind_t    p1_kind_reg, p2_kind_reg, p3_kind_reg;
    logic [W-1:0]           p1_a_reg, p1_b_reg;
    logic [W-1:0]           p1_inv_rd_reg;
    logic                   p1_inv_vld_reg;
    logic                   p2_zero_reg, p3_zero_reg;
    logic [W-1:0]           p2_fix_reg, p3_fix_reg;
    logic [W-1:0]           la_rd_reg, lb_rd_reg, al_rd_reg;
    logic                   la_vld_reg, lb_vld_reg;
    logic [W-1:0]           out_res_reg;
    logic                   out_err_reg;

    logic [W-1:0]           inv_eff;
    logic [W-1:0]           mul_b;
    logic                   p1_zero;
    logic [W-1:0]           p1_fix;
    logic [W-1:0]           la_addr;
    logic [W-1:0]           la_eff, lb_eff;
    logic [W:0]             sum;
    logic [W:0]             sum_fold;
    logic [W-1:0]           al_addr;
    logic [W-1:0]           res3;
    logic                   err3;

    // Next antilog value: double, reduce on overflow
    assign dbl     = {val_reg, 1'b0};
    assign dbl_red = dbl[7] ? (dbl ^ poly_reg) : dbl;

    // Build sequencer next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        val_next   = val_reg;
        anti_we    = 1'b0;
        issue      = 1'b0;
        case (state_reg)
            gflt_pkg::BLD_ANTI: begin
                anti_we  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                val_next = dbl_red[W-1:0];
                if (cnt_reg == gflt_pkg::ELEM_MAX) begin
                    state_next = gflt_pkg::BLD_INV;
                end
            end
            gflt_pkg::BLD_INV: begin
                issue    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == gflt_pkg::ELEM_MAX) begin
                    state_next = gflt_pkg::BLD_DRAIN;
                end
            end
            gflt_pkg::BLD_DRAIN: begin
                if (!bv1_reg) begin
                    state_next = gflt_pkg::BLD_IDLE;
                end
            end
            default: begin
                state_next = gflt_pkg::BLD_IDLE;
            end
        endcase
    end

    // Sequencer registers; restart on reset and on a polynomial write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg  <= gflt_pkg::POLY_RESET;
            state_reg <= gflt_pkg::BLD_ANTI;
            cnt_reg   <= '0;
            val_reg   <= gflt_pkg::ELEM_ONE;
            bv1_reg   <= 1'b0;
            bv2_reg   <= 1'b0;
        end else if (cfg_we) begin
            poly_reg  <= cfg_wdata;
            state_reg <= gflt_pkg::BLD_ANTI;
            cnt_reg   <= '0;
            val_reg   <= gflt_pkg::ELEM_ONE;
            bv1_reg   <= 1'b0;
            bv2_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            val_reg   <= val_next;
            bv1_reg   <= issue;
            bv2_reg   <= bv1_reg;
        end
    end

    // Carry the element index along the inverse build pipe
    always_ff @(posedge aclk) begin
        e1_reg <= cnt_reg;
        e2_reg <= e1_reg;
    end

    // Valid bits: cleared entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_vld_reg <= '0;
            inv_vld_reg <= '0;
        end else if (cfg_we) begin
            log_vld_reg <= '0;
            inv_vld_reg <= '0;
        end else begin
            if (anti_we) begin
                log_vld_reg[val_reg] <= 1'b1;
            end
            if (bv2_reg) begin
                inv_vld_reg[al_rd_reg] <= 1'b1;
            end
        end
    end

    // Table writes; later writes to an entry win
    always_ff @(posedge aclk) begin
        if (anti_we) begin
            antilog_mem[cnt_reg] <= val_reg;
            log_mem[val_reg]     <= cnt_reg;
        end
        if (bv2_reg) begin
            inv_mem[al_rd_reg] <= e2_reg;
        end
    end

    // Pipeline control
    assign bld_busy = (state_reg != gflt_pkg::BLD_IDLE);
    assign adv      = !out_v_reg || m_tready;
    assign rd_en    = adv || bld_busy;
    assign pop      = adv && !q_stat.empty;

    // Stage 1 lookups: select the second log operand, fix the simple results
    always_comb begin
        inv_eff = p1_inv_vld_reg ? p1_inv_rd_reg : gflt_pkg::ELEM_ZERO;
        mul_b   = (p1_kind_reg == gflt_pkg::CMD_CHECK) ? inv_eff : p1_b_reg;
        p1_zero = (p1_a_reg == gflt_pkg::ELEM_ZERO) || (mul_b == gflt_pkg::ELEM_ZERO);
        case (p1_kind_reg)
            gflt_pkg::CMD_INV: p1_fix = inv_eff;
            gflt_pkg::CMD_ONE: p1_fix = gflt_pkg::ELEM_ONE;
            default:           p1_fix = gflt_pkg::ELEM_ZERO;
        endcase
        la_addr = bld_busy ? cnt_reg : p1_a_reg;
    end

    // Stage 2: add logs, fold, pick antilog address
    always_comb begin
        la_eff   = la_vld_reg ? la_rd_reg : gflt_pkg::ELEM_ZERO;
        lb_eff   = lb_vld_reg ? lb_rd_reg : gflt_pkg::ELEM_ZERO;
        sum      = {1'b0, la_eff} + {1'b0, lb_eff};
        sum_fold = (sum > {1'b0, gflt_pkg::ELEM_MAX}) ? (sum - {1'b0, gflt_pkg::ELEM_MAX})
                                                     : sum;
        al_addr  = bld_busy ? (gflt_pkg::ELEM_MAX - la_eff) : sum_fold[W-1:0];
    end

    // Stage 3: final result select
    always_comb begin
        case (p3_kind_reg)
            gflt_pkg::CMD_MUL,
            gflt_pkg::CMD_CHECK: res3 = p3_zero_reg ? gflt_pkg::ELEM_ZERO : al_rd_reg;
            default:             res3 = p3_fix_reg;
        endcase
        err3 = (p3_kind_reg == gflt_pkg::CMD_ERR);
    end

    // Registered table reads; the log and antilog reads are shared with the build sequencer
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_inv_rd_reg  <= inv_mem[head_cmd.a];
            p1_inv_vld_reg <= inv_vld_reg[head_cmd.a];
        end
        if (rd_en) begin
            la_rd_reg  <= log_mem[la_addr];
            la_vld_reg <= log_vld_reg[la_addr];
            lb_rd_reg  <= log_mem[mul_b];
            lb_vld_reg <= log_vld_reg[mul_b];
            al_rd_reg  <= antilog_mem[al_addr];
        end
    end

    // Stage valid bits; hold the whole pipe while the output stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            p3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (adv) begin
            p1_v_reg  <= !q_stat.empty;
            p2_v_reg  <= p1_v_reg;
            p3_v_reg  <= p2_v_reg;
            out_v_reg <= p3_v_reg;
        end
    end

    // Stage payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_kind_reg <= head_cmd.kind;
            p1_a_reg    <= head_cmd.a;
            p1_b_reg    <= head_cmd.b;
            p2_kind_reg <= p1_kind_reg;
            p2_zero_reg <= p1_zero;
            p2_fix_reg  <= p1_fix;
            p3_kind_reg <= p2_kind_reg;
            p3_zero_reg <= p2_zero_reg;
            p3_fix_reg  <= p2_fix_reg;
            out_res_reg <= res3;
            out_err_reg <= err3;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_err_reg, out_res_reg};

endmodule

// File: sv/gf128_log_table_mult_inverse.sv
// GF(2^7) arithmetic unit built on log, antilog and inverse tables.
//
// Input channel s_*: one transaction carries op, operand_a and operand_b.
//   op 0 multiplies a by b, op 1 returns the inverse of a, op 2 returns
//   a times its inverse (1 for a zero or out-of-range a). On ops 0 and 1 an
//   operand_a of 128 or more gives result 0 with range_error set.
// Output channel m_*: one transaction per input, in order, carrying result
//   and range_error.
// Config: cfg_we with cfg_wdata writes the reduction polynomial.
//
// Throughput is one transaction per cycle while m_tready stays high and no
// table rebuild runs. A result passes through the command queue, then three
// registered table reads (inverse, two log reads, antilog) ahead of the
// output register.
// After reset, and after each polynomial write, the tables are rebuilt:
// antilog/log fill, then inverse fill, then drain, during which s_tready
// stays low.
// When the receiver holds m_tready low the lookup pipe freezes; the
// four-entry command queue keeps taking input until it is full.
module gf128_log_table_mult_inverse (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // op[1:0], operand_a[9:2], operand_b[16:10], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata     // result[6:0], range_error[7]
);

    logic                 push;
    logic                 pop;
    logic                 bld_busy;
    gflt_pkg::cmd_t       push_cmd;
    gflt_pkg::cmd_t       head_cmd;
    gflt_pkg::q_status_t  q_stat;

    gflt_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_fields (s_tdata[16:0]),
        .bld_busy (bld_busy),
        .q_stat   (q_stat),
        .push     (push),
        .cmd      (push_cmd)
    );

    gflt_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    gflt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .head_cmd  (head_cmd),
        .q_stat    (q_stat),
        .pop       (pop),
        .bld_busy  (bld_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: sv/gflt_checker.sv
module gflt_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       s_tready,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata
);

    // Hold a stalled result
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // No result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // Table rebuild blocks input after reset
    a_reset_build: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("s_tready high during table build after reset");

    // Table rebuild blocks input after a polynomial write
    a_cfg_build: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_tready)
        else $error("s_tready high during table build after config write");

    // A range error always carries a zero result
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7] |-> (m_tdata[6:0] == 7'd0))
        else $error("range_error with nonzero result");

endmodule

bind gf128_log_table_mult_inverse gflt_checker u_gflt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .cfg_we   (cfg_we),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/tb_gf128_log_table_mult_inverse.sv
`timescale 1ns / 1ps

module tb_gf128_log_table_mult_inverse;

    localparam int SETTLE_CYCLES = 10;

    typedef struct {
        logic [6:0] value;
        logic       range_err;
    } answer_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = gflt_pkg::POLY_RESET;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;

    // Field tables as the block should hold them
    logic [6:0] field_antilog [128];
    logic [6:0] field_log     [128];
    logic [6:0] field_inverse [128];

    answer_t pending_answers[$];
    int      error_count = 0;
    bit      sender_gaps = 1'b1;
    bit      rx_stalls   = 1'b1;
    int      rx_hold     = 0;

    gf128_log_table_mult_inverse uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Rebuild antilog and log in exponent order, then inverse in element order
    function automatic void rebuild_field_tables(input logic [7:0] poly);
        int v;
        int slot;
        for (int i = 0; i < 128; i++) begin
            field_antilog[i] = '0;
            field_log[i]     = '0;
            field_inverse[i] = '0;
        end
        for (int e = 0; e < 128; e++) begin
            if (e == 0) begin
                v = 1;
            end else begin
                v = int'(field_antilog[e-1]) << 1;
                if (v >= 128) begin
                    v = v ^ int'(poly);
                end
                v = v % 128;
            end
            field_antilog[e] = 7'(v);
            field_log[v]     = 7'(e);
        end
        for (int e = 0; e < 128; e++) begin
            slot = int'(field_antilog[127 - int'(field_log[e])]);
            field_inverse[slot] = 7'(e);
        end
    endfunction

    function automatic logic [6:0] gf_product(input logic [6:0] a, input logic [6:0] b);
        int sum;
        if (a == 0 || b == 0) begin
            return '0;
        end
        sum = int'(field_log[a]) + int'(field_log[b]);
        if (sum > 127) begin
            sum = sum - 127;
        end
        return field_antilog[sum];
    endfunction

    function automatic answer_t predict_answer(input logic [1:0] op_bits, input logic [7:0] a,
                                               input logic [6:0] b);
        answer_t ans;
        ans.value     = '0;
        ans.range_err = 1'b0;
        case (gflt_pkg::op_t'(op_bits))
            gflt_pkg::OP_MUL: begin
                if (a >= 128) begin
                    ans.range_err = 1'b1;
                end else begin
                    ans.value = gf_product(a[6:0], b);
                end
            end
            gflt_pkg::OP_INV: begin
                if (a >= 128) begin
                    ans.range_err = 1'b1;
                end else begin
                    ans.value = field_inverse[a[6:0]];
                end
            end
            gflt_pkg::OP_CHECK: begin
                if (a == 0 || a >= 128) begin
                    ans.value = 7'd1;
                end else begin
                    ans.value = gf_product(a[6:0], field_inverse[a[6:0]]);
                end
            end
            default: begin
                ans.value = '0;
            end
        endcase
        return ans;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Receiver: random stalls on m_tready
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold  = rx_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
            rx_hold  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                    : $urandom_range(10, 50);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check each result transaction first, then record the accepted input
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_answers.size() == 0) begin
                    $display("%0t: unexpected result transaction, got result %h range_error %b",
                             $time, m_tdata[6:0], m_tdata[7]);
                    error_count++;
                end else begin
                    want = pending_answers.pop_front();
                    if (m_tdata[6:0] !== want.value) begin
                        $display("%0t: result mismatch, expected %h got %h",
                                 $time, want.value, m_tdata[6:0]);
                        error_count++;
                    end
                    if (m_tdata[7] !== want.range_err) begin
                        $display("%0t: range_error mismatch, expected %b got %b",
                                 $time, want.range_err, m_tdata[7]);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pending_answers.push_back(predict_answer(s_tdata[1:0], s_tdata[9:2],
                                                         s_tdata[16:10]));
            end
        end
    end

    task automatic send_op(input gflt_pkg::op_t op, input logic [7:0] a, input logic [6:0] b);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, b, a, op};
        do @(posedge aclk); while (!s_tready);
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random_op();
        gflt_pkg::op_t op;
        logic [7:0]    a;
        logic [6:0]    b;
        int            r;
        op = gflt_pkg::op_t'($urandom_range(0, 2));
        r  = $urandom_range(0, 99);
        if (r < 5) begin
            a = 8'd0;
        end else if (r < 85) begin
            a = 8'($urandom_range(1, 127));
        end else begin
            a = 8'($urandom_range(128, 255));
        end
        b = ($urandom_range(0, 19) == 0) ? 7'd0 : 7'($urandom_range(0, 127));
        send_op(op, a, b);
    endtask

    // Drop valid and hold until every result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        // let the last accepted transaction reach the expected queue
        @(posedge aclk);
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_poly(input logic [7:0] poly);
        wait_idle();
        while (!s_tready) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= poly;
        @(posedge aclk);
        cfg_we <= 1'b0;
        rebuild_field_tables(poly);
        // advance past the start of the rebuild
        while (s_tready) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_op(gflt_pkg::OP_MUL,   8'd0,   7'd0);
        send_op(gflt_pkg::OP_MUL,   8'd0,   7'd77);
        send_op(gflt_pkg::OP_MUL,   8'd93,  7'd0);
        send_op(gflt_pkg::OP_MUL,   8'd1,   7'd1);
        send_op(gflt_pkg::OP_MUL,   8'd127, 7'd127);
        send_op(gflt_pkg::OP_MUL,   8'd2,   7'd64);
        send_op(gflt_pkg::OP_MUL,   8'd128, 7'd5);
        send_op(gflt_pkg::OP_MUL,   8'd255, 7'd127);
        send_op(gflt_pkg::OP_INV,   8'd0,   7'd0);
        send_op(gflt_pkg::OP_INV,   8'd1,   7'd0);
        send_op(gflt_pkg::OP_INV,   8'd127, 7'd127);
        send_op(gflt_pkg::OP_INV,   8'd128, 7'd0);
        send_op(gflt_pkg::OP_INV,   8'd200, 7'd3);
        send_op(gflt_pkg::OP_CHECK, 8'd0,   7'd0);
        send_op(gflt_pkg::OP_CHECK, 8'd1,   7'd0);
        send_op(gflt_pkg::OP_CHECK, 8'd127, 7'd127);
        send_op(gflt_pkg::OP_CHECK, 8'd128, 7'd0);
        send_op(gflt_pkg::OP_CHECK, 8'd255, 7'd0);
        send_op(gflt_pkg::OP_CHECK, 8'd42,  7'd99);
        wait_idle();
    endtask

    task automatic test_random_ops(input int count);
        for (int i = 0; i < count; i++) begin
            send_random_op();
        end
        wait_idle();
    endtask

    task automatic test_back_to_back(input int count);
        sender_gaps = 1'b0;
        rx_stalls   = 1'b0;
        for (int i = 0; i < count; i++) begin
            send_random_op();
        end
        wait_idle();
        sender_gaps = 1'b1;
        rx_stalls   = 1'b1;
    endtask

    // Bursts with the sender holding off until the pipe has drained
    task automatic test_drain_pauses();
        for (int burst = 0; burst < 4; burst++) begin
            for (int i = 0; i < 50; i++) begin
                send_random_op();
            end
            wait_idle();
        end
    endtask

    task automatic test_poly_sweep();
        logic [7:0] polys [6];
        polys[0] = 8'h80;
        polys[1] = 8'hFF;
        polys[2] = 8'h83;
        polys[3] = 8'hC1;
        polys[4] = 8'($urandom_range(128, 255));
        polys[5] = 8'($urandom_range(128, 255));
        foreach (polys[k]) begin
            write_poly(polys[k]);
            send_op(gflt_pkg::OP_MUL,   8'd127, 7'd127);
            send_op(gflt_pkg::OP_INV,   8'd0,   7'd0);
            send_op(gflt_pkg::OP_CHECK, 8'd3,   7'd0);
            test_random_ops(140);
        end
        write_poly(gflt_pkg::POLY_RESET);
        test_random_ops(60);
    endtask

    initial begin
        rebuild_field_tables(gflt_pkg::POLY_RESET);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_ops(500);
        test_back_to_back(300);
        test_drain_pauses();
        test_poly_sweep();

        wait_idle();
        if (error_count == 0 && pending_answers.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/gflt_pkg.sv
sv/gflt_front.sv
sv/gflt_fifo.sv
sv/gflt_back.sv
sv/gf128_log_table_mult_inverse.sv
sv/gflt_checker.sv
bench/tb_gf128_log_table_mult_inverse.sv
